>>> hdl/rsvm_pkg.sv
package rsvm_pkg;

	localparam int REGISTER_COUNT_DEF = 8;
	localparam int IP_INDEX_DEF       = 0;
	localparam int SP_INDEX_DEF       = 1;
	localparam int STACK_DEPTH_DEF    = 256;

	typedef enum logic [7:0] {
		OP_HALT = 8'd0, OP_PUSH = 8'd1, OP_PUSHI = 8'd2, OP_POP = 8'd3,
		OP_MOV = 8'd4, OP_MOVI = 8'd5, OP_ADD = 8'd6, OP_ADDI = 8'd7,
		OP_SUB = 8'd8, OP_SUBI = 8'd9, OP_MUL = 8'd10, OP_MULI = 8'd11,
		OP_DIV = 8'd12, OP_DIVI = 8'd13, OP_CMP = 8'd14, OP_CMPI = 8'd15,
		OP_JMP = 8'd16, OP_JE = 8'd17, OP_JNE = 8'd18, OP_JG = 8'd19,
		OP_JL = 8'd20, OP_JGE = 8'd21, OP_JLE = 8'd22
	} opcode_t;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_HALTED   = 3'd1;
	localparam logic [2:0] ST_BAD_OP   = 3'd2;
	localparam logic [2:0] ST_BAD_REG  = 3'd3;
	localparam logic [2:0] ST_DIV_ZERO = 3'd4;
	localparam logic [2:0] ST_STACK    = 3'd5;

	// ALU kinds for the two-operand group
	localparam logic [2:0] K_MOV = 3'd0;
	localparam logic [2:0] K_ADD = 3'd1;
	localparam logic [2:0] K_SUB = 3'd2;
	localparam logic [2:0] K_MUL = 3'd3;
	localparam logic [2:0] K_DIV = 3'd4;
	localparam logic [2:0] K_CMP = 3'd5;

	typedef struct packed {
		logic [7:0]         req_type;
		logic signed [63:0] operand_first;
		logic signed [63:0] operand_second;
	} req_t;

	typedef struct packed {
		logic signed [63:0] next_ip;
		logic [2:0]         status;
		logic               flag_equal;
		logic               flag_greater;
		logic               flag_less;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture request, read operands
		logic decode;    // check, fetch stack, start long ops
		logic mul_step;  // advance multiplier
		logic div_step;  // advance divider
		logic commit;    // write back and build result
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_mul;
		logic need_div;
		logic mul_done;
		logic div_done;
	} dp_stat_t;

endpackage

>>> hdl/rsvm_datapath.sv
module rsvm_datapath
	import rsvm_pkg::*;
#(
	parameter int REGISTER_COUNT = REGISTER_COUNT_DEF,
	parameter int IP_INDEX       = IP_INDEX_DEF,
	parameter int SP_INDEX       = SP_INDEX_DEF,
	parameter int STACK_DEPTH    = STACK_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	output rsp_t     rsp
);
	localparam int RW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
	localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	logic [63:0] regs_q [REGISTER_COUNT];
	logic [63:0] stack_q [STACK_DEPTH];
	logic        feq_q, fgt_q, flt_q, run_q;

	logic [7:0]  op_q;
	logic [63:0] a_q, b_q, src_q, dst_q, pop_q, res_q;
	logic [RW-1:0] ai_q;
	logic [2:0]  kind_q, st_q;
	logic        aok_q, bok_q;

	// index checks on raw operands; negative indices are out of range
	logic aok, bok;
	assign aok = ($unsigned(req.operand_first)  < 64'(REGISTER_COUNT));
	assign bok = ($unsigned(req.operand_second) < 64'(REGISTER_COUNT));

	logic [63:0] ip, sp;
	assign ip = regs_q[IP_INDEX];
	assign sp = regs_q[SP_INDEX];

	logic [63:0] sp_inc;
	assign sp_inc = sp + 64'd1;

	// status decided in decode
	logic [2:0] st_d;
	logic [2:0] kind_d;
	logic       reg_src;
	assign reg_src = ~op_q[0];
	assign kind_d = 3'((op_q - 8'd4) >> 1);

	// source operand as seen in decode; reads see ip already advanced
	logic [63:0] src_d;
	assign src_d = reg_src ? ((32'(RW'(b_q)) == IP_INDEX) ? ip + 64'd2
		: regs_q[RW'(b_q)]) : b_q;

	always_comb begin
		st_d = ST_OK;
		if (!run_q) st_d = ST_HALTED;
		else if (op_q == OP_HALT) st_d = ST_HALTED;
		else if (op_q == OP_PUSH || op_q == OP_PUSHI) begin
			if (op_q == OP_PUSH && !aok_q) st_d = ST_BAD_REG;
			else if (sp_inc >= 64'(STACK_DEPTH)) st_d = ST_STACK;
		end else if (op_q == OP_POP) begin
			if (!aok_q) st_d = ST_BAD_REG;
			else if (sp >= 64'(STACK_DEPTH)) st_d = ST_STACK;
		end else if (op_q >= OP_MOV && op_q <= OP_CMPI) begin
			if (!aok_q || (reg_src && !bok_q)) st_d = ST_BAD_REG;
			else if (kind_d == K_DIV && src_d == 64'd0) st_d = ST_DIV_ZERO;
		end else if (op_q > OP_JLE) st_d = ST_BAD_OP;
	end

	// multiplier: three 32x32 partial products (high x high is dropped), one per step
	logic [1:0]  mcnt_q;
	logic [63:0] macc_q;
	logic [31:0] mx, my;
	logic [63:0] pp, pp_sh;
	assign mx = mcnt_q[0] ? dst_q[63:32] : dst_q[31:0];
	assign my = mcnt_q[1] ? src_q[63:32] : src_q[31:0];
	assign pp = 64'(mx) * 64'(my);
	always_comb begin
		case (mcnt_q)
			2'd0:    pp_sh = pp;
			2'd3:    pp_sh = 64'd0;
			default: pp_sh = {pp[31:0], 32'd0};
		endcase
	end

	// divider: restoring, one bit per step on magnitudes
	logic [63:0] dq_q, dr_q, dd_q;
	logic [6:0]  dcnt_q;
	logic        dneg_q;
	logic [64:0] dtry;
	assign dtry = {dr_q, dq_q[63]} - {1'b0, dd_q};

	assign stat.need_mul = (kind_q == K_MUL);
	assign stat.need_div = (kind_q == K_DIV) && (st_q == ST_OK);
	assign stat.mul_done = (mcnt_q == 2'd3);
	assign stat.div_done = (dcnt_q == 7'd63);

	// next ip for the commit
	logic take;
	always_comb begin
		case (op_q)
			OP_JMP:  take = 1'b1;
			OP_JE:   take = feq_q;
			OP_JNE:  take = ~feq_q;
			OP_JG:   take = fgt_q;
			OP_JL:   take = flt_q;
			OP_JGE:  take = fgt_q | feq_q;
			default: take = flt_q | feq_q;
		endcase
	end

	logic [63:0] alu;
	always_comb begin
		case (kind_q)
			K_MOV:   alu = src_q;
			K_ADD:   alu = dst_q + src_q;
			K_SUB:   alu = dst_q - src_q;
			K_MUL:   alu = macc_q;
			K_DIV:   alu = dneg_q ? (64'd0 - dq_q) : dq_q;
			default: alu = dst_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REGISTER_COUNT; i++)
				regs_q[i] <= (i == SP_INDEX) ? '1 : '0;
			feq_q <= 1'b0;
			fgt_q <= 1'b0;
			flt_q <= 1'b0;
			run_q <= 1'b1;
		end else if (cmd.commit) begin
			if (st_q == ST_OK) begin
				if (op_q == OP_PUSH || op_q == OP_PUSHI) begin
					regs_q[SP_INDEX] <= sp_inc;
					regs_q[IP_INDEX] <= ip + 64'd2;
				end else if (op_q == OP_POP) begin
					// ip advances first, then load, then sp decrements
					regs_q[IP_INDEX] <= ip + 64'd2;
					regs_q[ai_q] <= pop_q;
					if (32'(ai_q) == IP_INDEX) regs_q[IP_INDEX] <= pop_q + 64'd1;
					if (32'(ai_q) == SP_INDEX) regs_q[SP_INDEX] <= pop_q - 64'd1;
					else regs_q[SP_INDEX] <= sp - 64'd1;
				end else if (op_q >= OP_MOV && op_q <= OP_CMPI) begin
					regs_q[IP_INDEX] <= ip + 64'd3;
					if (kind_q == K_CMP) begin
						feq_q <= dst_q == src_q;
						fgt_q <= $signed(dst_q) > $signed(src_q);
						flt_q <= $signed(dst_q) < $signed(src_q);
					end else begin
						regs_q[ai_q] <= alu;
						if (32'(ai_q) == IP_INDEX) regs_q[IP_INDEX] <= alu + 64'd1;
					end
				end else begin
					regs_q[IP_INDEX] <= take ? a_q : ip + 64'd2;
				end
			end else run_q <= 1'b0;
		end
	end

	// operand fetch and long units; payload, no reset
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req.req_type;
			a_q   <= req.operand_first;
			b_q   <= req.operand_second;
			aok_q <= aok;
			bok_q <= bok;
			ai_q  <= RW'(req.operand_first);
		end
		if (cmd.decode) begin
			kind_q <= kind_d;
			st_q   <= st_d;
			// reads see ip already advanced
			if (op_q >= OP_MOV && op_q <= OP_CMPI) begin
				src_q <= src_d;
				dst_q <= (32'(ai_q) == IP_INDEX) ? ip + 64'd2 : regs_q[ai_q];
			end else begin
				kind_q <= K_MOV;
			end
			if (op_q == OP_PUSH || op_q == OP_PUSHI) begin
				res_q <= (op_q == OP_PUSHI) ? a_q
					: ((32'(ai_q) == IP_INDEX) ? ip + 64'd1 : regs_q[ai_q]);
			end
			pop_q  <= stack_q[SW'(sp)];
			mcnt_q <= 2'd0;
			macc_q <= 64'd0;
		end
		if (cmd.mul_step) begin
			macc_q <= macc_q + pp_sh;
			mcnt_q <= mcnt_q + 2'd1;
		end
		if (cmd.div_step) begin
			if (dcnt_q == 7'd127) begin
				dq_q   <= dst_q[63] ? 64'd0 - dst_q : dst_q;
				dd_q   <= src_q[63] ? 64'd0 - src_q : src_q;
				dr_q   <= 64'd0;
				dneg_q <= dst_q[63] ^ src_q[63];
				dcnt_q <= 7'd0;
			end else begin
				if (!dtry[64]) dr_q <= dtry[63:0];
				else dr_q <= {dr_q[62:0], dq_q[63]};
				dq_q   <= {dq_q[62:0], ~dtry[64]};
				dcnt_q <= dcnt_q + 7'd1;
			end
		end else if (cmd.decode) begin
			dcnt_q <= 7'd127;
		end
		if (cmd.commit && st_q == ST_OK && (op_q == OP_PUSH || op_q == OP_PUSHI))
			stack_q[SW'(sp_inc)] <= res_q;
	end

	// result reflects committed state from the cycle after commit
	logic [2:0] rst_q;
	always_ff @(posedge clk) begin
		if (cmd.commit) rst_q <= st_q;
	end
	assign rsp.next_ip      = regs_q[IP_INDEX];
	assign rsp.status       = rst_q;
	assign rsp.flag_equal   = feq_q;
	assign rsp.flag_greater = fgt_q;
	assign rsp.flag_less    = flt_q;

endmodule

>>> hdl/rsvm_ctrl.sv
module rsvm_ctrl
	import rsvm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_DEC, S_MUL, S_DIV, S_COMMIT, S_OUT
	} state_t;

	state_t state_q;
	logic   ov_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = ov_q;

	always_comb begin
		cmd = '0;
		cmd.load     = (state_q == S_IDLE) && in_valid;
		cmd.decode   = (state_q == S_DEC);
		cmd.mul_step = (state_q == S_MUL);
		cmd.div_step = (state_q == S_DIV);
		cmd.commit   = (state_q == S_COMMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE:   if (in_valid) state_q <= S_DEC;
				S_DEC:    state_q <= S_MUL;
				S_MUL: begin
					// go on to divide or commit when not a multiply or once the multiply is done
					if (!stat.need_mul || stat.mul_done)
						state_q <= stat.need_div ? S_DIV : S_COMMIT;
				end
				S_DIV:    if (stat.div_done) state_q <= S_COMMIT;
				S_COMMIT: begin
					state_q <= S_OUT;
					ov_q    <= 1'b1;
				end
				S_OUT: begin
					if (!out_stall) begin
						ov_q    <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> hdl/register_stack_vm_execute_unit_top.sv
// Each instruction is loaded, decoded, passes through the multiplier (32x32
// partial products) or the bit-serial divider if needed, then commits.
// Throughput: one instruction at a time; next input is taken the cycle
// after the result transfer.
// Reset (arst_n low): registers zero, stack pointer all ones, flags clear,
// running set; stack contents undefined until written.
module register_stack_vm_execute_unit_top
	import rsvm_pkg::*;
#(
	parameter int REGISTER_COUNT = REGISTER_COUNT_DEF,
	parameter int IP_INDEX       = IP_INDEX_DEF,
	parameter int SP_INDEX       = SP_INDEX_DEF,
	parameter int STACK_DEPTH    = STACK_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output rsp_t out_data
);
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer: load, decode, long ops, commit, hold result
	rsvm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// register file, stack memory, multiplier and divider
	rsvm_datapath #(
		.REGISTER_COUNT (REGISTER_COUNT),
		.IP_INDEX       (IP_INDEX),
		.SP_INDEX       (SP_INDEX),
		.STACK_DEPTH    (STACK_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (in_data),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (out_data)
	);

endmodule

>>> hdl/rsvm_checker.sv
module rsvm_checker
	import rsvm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input rsp_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result dropped while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= ST_STACK)
		else $error("bad status code");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.flag_greater && out_data.flag_less))
		else $error("greater and less both set");
endmodule

bind register_stack_vm_execute_unit_top rsvm_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
